// File: design/sparse_chunked_bitmap_top_macros.svh
// ----------------------------------------------------------------------------
// Sparse chunked bitmap: assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SPARSE_CHUNKED_BITMAP_TOP_MACROS_SVH
`define SPARSE_CHUNKED_BITMAP_TOP_MACROS_SVH

// check outside reset
`define SCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every edge, reset included
`define SCB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/scb_pkg.sv
// ----------------------------------------------------------------------------
// Sparse chunked bitmap package
// Geometry constants and the command and response types of the stores.
// ----------------------------------------------------------------------------
package scb_pkg;

  localparam int CHUNK_SIDE = 16;
  localparam int MAX_CHUNKS = 64;
  localparam int COORD_BITS = 16;

  localparam int SIDE_BITS  = $clog2(CHUNK_SIDE);
  localparam int CELLS      = CHUNK_SIDE * CHUNK_SIDE;
  localparam int OFF_BITS   = 2 * SIDE_BITS;
  localparam int SLOT_BITS  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int COUNT_BITS = $clog2(MAX_CHUNKS + 1);
  localparam int TAG_HALF   = COORD_BITS - SIDE_BITS;
  localparam int TAG_BITS   = 2 * TAG_HALF;

  typedef struct packed {
    logic                 rd;
    logic                 wr;
    logic [SLOT_BITS-1:0] addr;
    logic [TAG_BITS-1:0]  wdata;
  } tag_cmd_t;

  typedef struct packed {
    logic                 rd;
    logic                 wr;
    logic [SLOT_BITS-1:0] addr;
    logic [CELLS-1:0]     wdata;
  } bit_cmd_t;

  typedef struct packed {
    logic             valid;
    logic [CELLS-1:0] row;
  } bit_rsp_t;

endpackage

// File: design/scb_tag_ram.sv
// ----------------------------------------------------------------------------
// Sparse chunked bitmap: chunk tag table
// One tag per slot, one read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module scb_tag_ram
  import scb_pkg::*;
(
  input  logic                clk,
  input  tag_cmd_t            cmd,
  output logic [TAG_BITS-1:0] rdata
);

  logic [TAG_BITS-1:0] mem [MAX_CHUNKS];
  logic [TAG_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[cmd.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/scb_bit_ram.sv
// ----------------------------------------------------------------------------
// Sparse chunked bitmap: cell bit store
// One row of bits per slot; a per-row valid flag marks unwritten rows, which read with valid low.
// ----------------------------------------------------------------------------
module scb_bit_ram
  import scb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  bit_cmd_t cmd,
  output bit_rsp_t rsp
);

  logic [CELLS-1:0]      mem [MAX_CHUNKS];
  logic [MAX_CHUNKS-1:0] row_ok_r;
  logic [CELLS-1:0]      row_r;
  logic                  valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ok_r <= '0;
    end else if (cmd.wr) begin
      row_ok_r[cmd.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[cmd.addr] <= cmd.wdata;
    end
    if (cmd.rd) begin
      row_r   <= mem[cmd.addr];
      valid_r <= row_ok_r[cmd.addr];
    end
  end

  assign rsp.valid = valid_r;
  assign rsp.row   = row_r;

endmodule

// File: design/sparse_chunked_bitmap_top.sv
// ----------------------------------------------------------------------------
// Sparse chunked bitmap
// Signed-position bitmap held in square chunks allocated on first write.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_req_type, in_pos_x, in_pos_y and in_bit_value with start high;
//   the item is taken on an edge where busy is low. busy stays high until the
//   result has been produced.
//   The result appears on out_bit_out and out_status for one cycle with
//   out_valid high. A query returns the stored bit (0 for an unallocated
//   chunk); a write echoes its value, or returns status 1 when the table is
//   full and the chunk is new.
//   Flow: a single comparator walks the tag table one slot per cycle
//   behind a registered tag read. A query that misses, or a write dropped
//   for a full table, is answered at the end of the walk. A hit, or a write
//   that takes a new slot, goes on to a read of its bit-store row (ST_ROW)
//   and then to the result (ST_FIN), where a write stores the row back. The
//   next item may be started in the cycle the result is shown.
//   Reset zeroes the slot count and marks every bit-store row as unwritten,
//   so it reads as zero; no clearing pass is run.
//   The receiver cannot stall: every result must be taken when shown.
// ----------------------------------------------------------------------------
`include "sparse_chunked_bitmap_top_macros.svh"

module sparse_chunked_bitmap_top
  import scb_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_req_type,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic                         in_bit_value,
  output logic                         out_valid,
  output logic                         out_bit_out,
  output logic                         out_status
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_ROW  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  localparam logic [COUNT_BITS-1:0] USED_FULL = COUNT_BITS'(MAX_CHUNKS);

  logic [1:0]            state_r, state_nxt;
  logic [COUNT_BITS-1:0] idx_r, idx_nxt;
  logic                  pend_r, pend_nxt;
  logic [SLOT_BITS-1:0]  pend_idx_r, pend_idx_nxt;
  logic [SLOT_BITS-1:0]  slot_r, slot_nxt;
  logic [COUNT_BITS-1:0] used_r, used_nxt;
  logic                  type_r, type_nxt;
  logic                  val_r, val_nxt;
  logic [TAG_BITS-1:0]   tag_r, tag_nxt;
  logic [OFF_BITS-1:0]   off_r, off_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_bit_r, out_bit_nxt;
  logic                  out_status_r, out_status_nxt;

  tag_cmd_t            tag_cmd;
  logic [TAG_BITS-1:0] tag_rdata;
  bit_cmd_t            bit_cmd;
  bit_rsp_t            bit_rsp;
  logic [CELLS-1:0]    row_mod;
  logic                hit;

  scb_tag_ram u_tag_ram (
    .clk   (clk),
    .cmd   (tag_cmd),
    .rdata (tag_rdata)
  );

  scb_bit_ram u_bit_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (bit_cmd),
    .rsp   (bit_rsp)
  );

  assign hit = pend_r && (tag_rdata == tag_r);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    pend_nxt       = 1'b0;
    pend_idx_nxt   = pend_idx_r;
    slot_nxt       = slot_r;
    used_nxt       = used_r;
    type_nxt       = type_r;
    val_nxt        = val_r;
    tag_nxt        = tag_r;
    off_nxt        = off_r;
    out_valid_nxt  = 1'b0;
    out_bit_nxt    = out_bit_r;
    out_status_nxt = out_status_r;
    tag_cmd        = '0;
    bit_cmd        = '0;
    row_mod        = bit_rsp.valid ? bit_rsp.row : '0;
    row_mod[off_r] = val_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          type_nxt  = in_req_type;
          val_nxt   = in_bit_value;
          tag_nxt   = {in_pos_x[COORD_BITS-1:SIDE_BITS], in_pos_y[COORD_BITS-1:SIDE_BITS]};
          off_nxt   = {in_pos_y[SIDE_BITS-1:0], in_pos_x[SIDE_BITS-1:0]};
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          slot_nxt  = pend_idx_r;
          state_nxt = ST_ROW;
        end else if (idx_r < used_r) begin
          tag_cmd.rd   = 1'b1;
          tag_cmd.addr = idx_r[SLOT_BITS-1:0];
          pend_nxt     = 1'b1;
          pend_idx_nxt = idx_r[SLOT_BITS-1:0];
          idx_nxt      = idx_r + 1'b1;
        end else if (!pend_r) begin
          if (!type_r) begin
            out_valid_nxt  = 1'b1;
            out_bit_nxt    = 1'b0;
            out_status_nxt = 1'b0;
            state_nxt      = ST_IDLE;
          end else if (used_r == USED_FULL) begin
            out_valid_nxt  = 1'b1;
            out_bit_nxt    = 1'b0;
            out_status_nxt = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            tag_cmd.wr    = 1'b1;
            tag_cmd.addr  = used_r[SLOT_BITS-1:0];
            tag_cmd.wdata = tag_r;
            slot_nxt      = used_r[SLOT_BITS-1:0];
            used_nxt      = used_r + 1'b1;
            state_nxt     = ST_ROW;
          end
        end
      end
      ST_ROW: begin
        bit_cmd.rd   = 1'b1;
        bit_cmd.addr = slot_r;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = 1'b0;
        if (type_r) begin
          bit_cmd.wr    = 1'b1;
          bit_cmd.addr  = slot_r;
          bit_cmd.wdata = row_mod;
          out_bit_nxt   = val_r;
        end else begin
          out_bit_nxt = bit_rsp.valid & bit_rsp.row[off_r];
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pend_idx_r   <= pend_idx_nxt;
    slot_r       <= slot_nxt;
    type_r       <= type_nxt;
    val_r        <= val_nxt;
    tag_r        <= tag_nxt;
    off_r        <= off_nxt;
    out_bit_r    <= out_bit_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy        = (state_r != ST_IDLE);
  assign out_valid   = out_valid_r;
  assign out_bit_out = out_bit_r;
  assign out_status  = out_status_r;

  `SCB_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted item did not raise busy")
  `SCB_ASSERT(a_result_after_work, out_valid |-> $past(busy), "result without work in progress")
  `SCB_ASSERT(a_full_on_drop, out_valid && out_status |-> used_r == USED_FULL, "drop flagged with free slots")
  `SCB_ASSERT_ALWAYS(a_used_bound, !rst_n || used_r <= USED_FULL, "slot count beyond table size")

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse chunked bitmap testbench
// Drives queries and writes at signed positions through the start/busy
// handshake and checks every result against a bitmap predictor kept here.
// The predictor keeps its own chunk key list, allocation count and bit
// store. Directed cases cover the coordinate extremes, chunk edges either
// side of zero, fresh chunks and a full key table. Random traffic then works
// mostly in allocated chunks, with random positions mixed in, both before
// and after the table has filled.
// ----------------------------------------------------------------------------
module tb_top;
  import scb_pkg::*;

  localparam int   IDLE_LIMIT   = 4000;
  localparam int   DRAIN_CYCLES = 2 * (MAX_CHUNKS + 4);
  localparam int   MAX_GAP      = 17;
  localparam int   GROWTH_CAP   = 48;
  localparam logic REQ_QUERY    = 1'b0;
  localparam logic REQ_WRITE    = 1'b1;
  localparam logic ST_OK        = 1'b0;
  localparam logic ST_FULL      = 1'b1;

  typedef struct packed {
    logic bit_val;
    logic full;
  } cell_result_t;

  logic                         clk;
  logic                         rst_n        = 1'b0;
  logic                         start        = 1'b0;
  logic                         busy;
  logic                         in_req_type  = REQ_QUERY;
  logic signed [COORD_BITS-1:0] in_pos_x     = '0;
  logic signed [COORD_BITS-1:0] in_pos_y     = '0;
  logic                         in_bit_value = 1'b0;
  logic                         out_valid;
  logic                         out_bit_out;
  logic                         out_status;

  logic [TAG_BITS-1:0] chunk_keys [MAX_CHUNKS];
  bit                  cell_store [MAX_CHUNKS * CELLS];
  int                  chunks_taken = 0;
  cell_result_t        pending_results [$];
  int                  errors       = 0;
  int                  burst_left   = 0;
  int                  quiet_cycles = 0;

  sparse_chunked_bitmap_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req_type  (in_req_type),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_bit_value (in_bit_value),
    .out_valid    (out_valid),
    .out_bit_out  (out_bit_out),
    .out_status   (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic cell_result_t apply_to_bitmap(logic kind, logic [COORD_BITS-1:0] px,
                                                   logic [COORD_BITS-1:0] py, logic val);
    logic [TAG_BITS-1:0] key;
    int                  slot;
    int                  offset;
    cell_result_t        r;
    key    = {px[COORD_BITS-1:SIDE_BITS], py[COORD_BITS-1:SIDE_BITS]};
    offset = int'(px[SIDE_BITS-1:0]) + CHUNK_SIDE * int'(py[SIDE_BITS-1:0]);
    slot   = -1;
    for (int i = 0; i < chunks_taken; i++) begin
      if (slot < 0 && chunk_keys[i] == key) slot = i;
    end
    r.bit_val = 1'b0;
    r.full    = ST_OK;
    if (kind == REQ_QUERY) begin
      if (slot >= 0) r.bit_val = cell_store[slot * CELLS + offset];
      return r;
    end
    if (slot < 0) begin
      if (chunks_taken >= MAX_CHUNKS) begin
        r.full = ST_FULL;
        return r;
      end
      slot = chunks_taken;
      chunk_keys[slot] = key;
      chunks_taken++;
    end
    cell_store[slot * CELLS + offset] = val;
    r.bit_val = val;
    return r;
  endfunction

  task automatic send_item(logic kind, logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py,
                           logic val);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 40) == 0) burst_left = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req_type  <= kind;
    in_pos_x     <= px;
    in_pos_y     <= py;
    in_bit_value <= val;
    start        <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(apply_to_bitmap(kind, px, py, val));
  endtask

  task automatic send_in_known_chunk(logic kind, logic val);
    logic [TAG_BITS-1:0] key;
    key = chunk_keys[$urandom_range(0, chunks_taken - 1)];
    send_item(kind, {key[TAG_BITS-1:TAG_HALF], SIDE_BITS'($urandom)},
              {key[TAG_HALF-1:0], SIDE_BITS'($urandom)}, val);
  endtask

  task automatic note_failure(string what);
    errors++;
    if (errors <= 10) $display("%0t: %s", $time, what);
  endtask

  task automatic check_blank_map();
    send_item(REQ_QUERY, 16'sh0000, 16'sh0000, 1'b1);
    send_item(REQ_QUERY, 16'sh8000, 16'sh8000, 1'b0);
    send_item(REQ_QUERY, 16'sh7fff, 16'sh7fff, 1'b1);
    send_item(REQ_QUERY, 16'shffff, 16'sh0000, 1'b0);
  endtask

  task automatic check_corners();
    send_item(REQ_WRITE, 16'sh8000, 16'sh8000, 1'b1);
    send_item(REQ_WRITE, 16'sh7fff, 16'sh7fff, 1'b1);
    send_item(REQ_WRITE, 16'shffff, 16'shffff, 1'b1);
    send_item(REQ_WRITE, 16'sh0000, 16'sh0000, 1'b1);
    send_item(REQ_WRITE, 16'sh000f, -16'sd16, 1'b1);
    send_item(REQ_WRITE, -16'sd17, 16'sh0010, 1'b1);
    send_item(REQ_QUERY, 16'sh8000, 16'sh8000, 1'b0);
    send_item(REQ_QUERY, 16'sh7fff, 16'sh7fff, 1'b0);
    send_item(REQ_QUERY, 16'shffff, 16'shffff, 1'b0);
    send_item(REQ_QUERY, 16'sh000f, -16'sd16, 1'b0);
    send_item(REQ_QUERY, -16'sd17, 16'sh0010, 1'b0);
    // fresh chunk: only the written bit is set
    send_item(REQ_QUERY, -16'sd2, 16'shffff, 1'b1);
    send_item(REQ_QUERY, 16'sh0001, 16'sh0000, 1'b0);
    send_item(REQ_WRITE, 16'shffff, 16'shffff, 1'b0);
    send_item(REQ_QUERY, 16'shffff, 16'shffff, 1'b1);
  endtask

  task automatic run_traffic(int count, int cap);
    logic kind;
    logic val;
    for (int n = 0; n < count; n++) begin
      kind = 1'($urandom);
      val  = 1'($urandom);
      if ($urandom_range(0, 99) < 75 && chunks_taken > 0) begin
        send_in_known_chunk(kind, val);
      end else begin
        if (kind == REQ_WRITE && cap < MAX_CHUNKS && chunks_taken >= cap) kind = REQ_QUERY;
        send_item(kind, 16'($urandom), 16'($urandom), val);
      end
    end
  endtask

  task automatic fill_tag_table();
    while (chunks_taken < MAX_CHUNKS)
      send_item(REQ_WRITE, 16'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic check_full_table();
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    for (int n = 0; n < 3; n++) begin
      px = 16'($urandom);
      py = 16'($urandom);
      send_item(REQ_WRITE, px, py, 1'b1);
      send_item(REQ_QUERY, px, py, 1'b0);
    end
    send_in_known_chunk(REQ_WRITE, 1'b1);
  endtask

  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        note_failure("result with no item outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_bit_out !== want.bit_val)
          note_failure($sformatf("bit_out expected %0b got %0b", want.bit_val, out_bit_out));
        if (out_status !== want.full)
          note_failure($sformatf("status expected %0b got %0b", want.full, out_status));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("sparse_chunked_bitmap_top verification failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    check_blank_map();
    check_corners();
    run_traffic(700, GROWTH_CAP);
    fill_tag_table();
    check_full_table();
    run_traffic(650, MAX_CHUNKS);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("sparse_chunked_bitmap_top verification clean");
    else
      $display("sparse_chunked_bitmap_top verification failed");
    $finish;
  end

endmodule
